/* sv/gfm_pkg.sv */
// Package with the data types, constants and step function of the GF(2^128) multiplier.
`default_nettype none

package gfm_pkg;

  localparam int unsigned GFM_WIDTH           = 128;
  localparam int unsigned GFM_STEPS_PER_STAGE = 8;
  localparam int unsigned GFM_NUM_STAGES      = GFM_WIDTH / GFM_STEPS_PER_STAGE;

  localparam logic [GFM_WIDTH-1:0] GFM_REDUCE = {8'he1, {(GFM_WIDTH-8){1'b0}}};

  typedef struct packed {
    logic [GFM_WIDTH-1:0] x;
    logic [GFM_WIDTH-1:0] v;
    logic [GFM_WIDTH-1:0] acc;
  } gfm_data_t;

  function automatic gfm_data_t gfm_steps(input gfm_data_t d);
    gfm_data_t r;
    logic      carry;
    r = d;
    for (int unsigned i = 0; i < GFM_STEPS_PER_STAGE; i++) begin
      if (r.x[GFM_WIDTH-1]) begin
        r.acc = r.acc ^ r.v;
      end
      carry = r.v[0];
      r.v   = r.v >> 1;
      if (carry) begin
        r.v = r.v ^ GFM_REDUCE;
      end
      r.x = r.x << 1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/gfm_stage.sv */
// One pipeline stage that runs eight multiply steps and registers the word with its valid bit.
`default_nettype none

module gfm_stage
  import gfm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire gfm_data_t in_data,
  output logic           valid_r,
  output gfm_data_t      data_r
);

  logic      valid_nxt;
  gfm_data_t data_nxt;

  always_comb begin
    valid_nxt = in_valid;
    data_nxt  = gfm_steps(in_data);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_nxt) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/gf128_multiply_unit.sv */
// Top level of the pipelined GCM GF(2^128) multiplier.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+----------------------------------
//   input    | start, busy           | in_x_hi, in_x_lo, in_y_hi, in_y_lo
//   result   | out_valid (strobe)    | out_z_hi, out_z_lo
//
// A word is taken in every cycle; busy stays low.
// The product is formed by sixteen registered stages of eight bit steps each.
// Reset clears the valid bits of all stages; words in flight are dropped.
// The receiver cannot stall, so the pipeline always advances.
`default_nettype none

module gf128_multiply_unit
  import gfm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] in_x_hi,
  input  wire logic [63:0] in_x_lo,
  input  wire logic [63:0] in_y_hi,
  input  wire logic [63:0] in_y_lo,
  output logic             out_valid,
  output logic [63:0]      out_z_hi,
  output logic [63:0]      out_z_lo
);

  logic      stage_valid [0:GFM_NUM_STAGES];
  gfm_data_t stage_data  [0:GFM_NUM_STAGES];

  assign busy = 1'b0;

  always_comb begin
    stage_valid[0]    = start & ~busy;
    stage_data[0].x   = {in_x_hi, in_x_lo};
    stage_data[0].v   = {in_y_hi, in_y_lo};
    stage_data[0].acc = '0;
  end

  for (genvar s = 0; s < GFM_NUM_STAGES; s++) begin : g_stage
    gfm_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (stage_valid[s]),
      .in_data  (stage_data[s]),
      .valid_r  (stage_valid[s+1]),
      .data_r   (stage_data[s+1])
    );
  end

  assign out_valid = stage_valid[GFM_NUM_STAGES];
  assign out_z_hi  = stage_data[GFM_NUM_STAGES].acc[127:64];
  assign out_z_lo  = stage_data[GFM_NUM_STAGES].acc[63:0];

`ifndef SYNTH
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##GFM_NUM_STAGES out_valid)
    else $error("Accepted word did not produce a result after the pipeline latency.");

  a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, GFM_NUM_STAGES))
    else $error("Result strobe without a matching accepted word.");

  a_zero_x : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_x_hi == 64'd0 && in_x_lo == 64'd0)
      |-> ##GFM_NUM_STAGES (out_z_hi == 64'd0 && out_z_lo == 64'd0))
    else $error("Zero operand gave a nonzero product.");
`endif

endmodule

`default_nettype wire

/* bench/gf128_product_checker.sv */
// Checker that predicts and compares every GF(2^128) product of the multiplier.
module gf128_product_checker
  import gfm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [63:0] in_x_hi,
  input  logic [63:0] in_x_lo,
  input  logic [63:0] in_y_hi,
  input  logic [63:0] in_y_lo,
  input  logic        out_valid,
  input  logic [63:0] out_z_hi,
  input  logic [63:0] out_z_lo,
  output int          mismatch_count,
  output int          products_pending
);

  typedef logic [GFM_WIDTH-1:0] block_t;

  block_t expected_products[$];

  // The first coefficient is the top bit; each step multiplies V by x modulo the GCM polynomial.
  function automatic block_t gf128_product(input block_t x, input block_t y);
    block_t acc;
    block_t v;
    logic   lsb;
    acc = '0;
    v   = y;
    for (int n = GFM_WIDTH - 1; n >= 0; n--) begin
      if (x[n]) begin
        acc = acc ^ v;
      end
      lsb = v[0];
      v   = v >> 1;
      if (lsb) begin
        v[GFM_WIDTH-1 -: 8] = v[GFM_WIDTH-1 -: 8] ^ 8'he1;
      end
    end
    return acc;
  endfunction

  always @(posedge clk) begin
    block_t want;
    if (rst_n && out_valid !== 1'b0) begin
      if (out_valid !== 1'b1) begin
        $error("out_valid is unknown");
        mismatch_count++;
      end else if (expected_products.size() == 0) begin
        $error("product word with none expected: z_hi %h z_lo %h", out_z_hi, out_z_lo);
        mismatch_count++;
      end else begin
        want = expected_products.pop_front();
        if (out_z_hi !== want[127:64]) begin
          $error("z_hi expected %h actual %h", want[127:64], out_z_hi);
          mismatch_count++;
        end
        if (out_z_lo !== want[63:0]) begin
          $error("z_lo expected %h actual %h", want[63:0], out_z_lo);
          mismatch_count++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      expected_products.push_back(gf128_product({in_x_hi, in_x_lo}, {in_y_hi, in_y_lo}));
    end
    products_pending = expected_products.size();
  end

endmodule

/* bench/testbench.sv */
// Top of the multiplier bench: clock, reset, operand stimulus and the final verdict.
module testbench;

  localparam int RANDOM_WORDS = 630;
  localparam int QUIET_TAIL   = 100;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic [127:0] GF_ONE  = {1'b1, 127'b0};
  localparam logic [127:0] GF_LAST = 128'h1;
  localparam logic [127:0] ALL_SET = '1;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [63:0] in_x_hi;
  logic [63:0] in_x_lo;
  logic [63:0] in_y_hi;
  logic [63:0] in_y_lo;
  logic        out_valid;
  logic [63:0] out_z_hi;
  logic [63:0] out_z_lo;
  int          mismatch_count;
  int          products_pending;
  int          cycle_count;

  gf128_multiply_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_x_hi  (in_x_hi),
    .in_x_lo  (in_x_lo),
    .in_y_hi  (in_y_hi),
    .in_y_lo  (in_y_lo),
    .out_valid(out_valid),
    .out_z_hi (out_z_hi),
    .out_z_lo (out_z_lo)
  );

  gf128_product_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_x_hi         (in_x_hi),
    .in_x_lo         (in_x_lo),
    .in_y_hi         (in_y_hi),
    .in_y_lo         (in_y_lo),
    .out_valid       (out_valid),
    .out_z_hi        (out_z_hi),
    .out_z_lo        (out_z_lo),
    .mismatch_count  (mismatch_count),
    .products_pending(products_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [127:0] random_block();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // Mostly dense operands, with zeros, all-ones, single bits and half-empty values mixed in.
  function automatic logic [127:0] random_operand();
    logic [127:0] r;
    r = random_block();
    case ($urandom_range(0, 11))
      0: r = '0;
      1: r = ALL_SET;
      2: r = GF_LAST << $urandom_range(0, 127);
      3: r[127:64] = '0;
      4: r[63:0] = '0;
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_word(input logic [127:0] x, input logic [127:0] y);
    start = 1'b1;
    {in_x_hi, in_x_lo} = x;
    {in_y_hi, in_y_lo} = y;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic idle_burst(input int cycles);
    start = 1'b0;
    {in_x_hi, in_x_lo} = random_block();
    {in_y_hi, in_y_lo} = random_block();
    repeat (cycles) @(negedge clk);
  endtask

  task automatic wait_for_drain();
    start = 1'b0;
    while (products_pending != 0) @(negedge clk);
  endtask

  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_x_hi = '0;
    in_x_lo = '0;
    in_y_hi = '0;
    in_y_lo = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_word('0, '0);
    send_word(ALL_SET, ALL_SET);
    send_word('0, random_block());
    send_word(random_block(), '0);
    send_word(GF_ONE, random_block());
    send_word(random_block(), GF_ONE);
    send_word(GF_ONE, GF_ONE);
    send_word(GF_LAST, GF_LAST);
    send_word(GF_ONE, GF_LAST);
    send_word(GF_LAST, ALL_SET);
    send_word(ALL_SET, GF_ONE);
    send_word({64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa},
              {64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555});
    send_word({64'hffff_ffff_ffff_ffff, 64'h0}, {64'h0, 64'hffff_ffff_ffff_ffff});
    send_word({64'h0, 64'hffff_ffff_ffff_ffff}, {64'hffff_ffff_ffff_ffff, 64'h0});
    send_word(128'h0388dace60b6a392f328c2b971b2fe78, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e);
    send_word(random_block(), random_block());
    idle_burst(3);
    send_word(GF_LAST << 63, GF_LAST << 64);
    send_word(random_block(), random_block());
    wait_for_drain();

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 2) begin
        wait_for_drain();
      end
      if (n < RANDOM_WORDS - QUIET_TAIL && (n / 64) % 3 != 2 && $urandom_range(0, 3) == 0) begin
        idle_burst($urandom_range(1, 15));
      end
      send_word(random_operand(), random_operand());
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && products_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/gfm_pkg.sv
sv/gfm_stage.sv
sv/gf128_multiply_unit.sv
bench/gf128_product_checker.sv
bench/testbench.sv
